// ----- hw/rtl/utf8esc_pkg.sv -----
// ----------------------------------------------------------------------------
// utf8esc_pkg
// Shared types, codes and character constants for the UTF-8 to escape
// converter: the job record passed from the decoder to the serializer.
// ----------------------------------------------------------------------------
`default_nettype none

package utf8esc_pkg;

	// Input opcodes
	localparam logic OP_DATA = 1'b0;
	localparam logic OP_END  = 1'b1;

	// Result status codes
	localparam logic [1:0] ST_OK  = 2'd0;
	localparam logic [1:0] ST_END = 2'd1;
	localparam logic [1:0] ST_BAD = 2'd2;

	// ASCII characters
	localparam logic [6:0] CH_TAB    = 7'h09;
	localparam logic [6:0] CH_LF     = 7'h0A;
	localparam logic [6:0] CH_SPACE  = 7'h20;
	localparam logic [6:0] CH_TILDE  = 7'h7E;
	localparam logic [6:0] CH_DEL    = 7'h7F;
	localparam logic [6:0] CH_BSLASH = 7'h5C;
	localparam logic [6:0] CH_U      = 7'h75;
	localparam logic [6:0] CH_ZERO   = 7'h30;
	localparam logic [6:0] CH_LOW_A  = 7'h61;

	// Code point limits
	localparam logic [20:0] CP_DEL     = 21'h00007F;
	localparam logic [20:0] CP_MIN2    = 21'h000080;
	localparam logic [20:0] CP_MAX2    = 21'h0007FF;
	localparam logic [20:0] CP_MIN3    = 21'h000800;
	localparam logic [20:0] CP_MAX3    = 21'h00FFFF;
	localparam logic [20:0] CP_MIN4    = 21'h010000;
	localparam logic [20:0] CP_MAX4    = 21'h10FFFF;
	localparam logic [20:0] CP_SIX_DIG = 21'h100000;

	// Sequence lengths
	localparam logic [2:0] LEN_2 = 3'd2;
	localparam logic [2:0] LEN_3 = 3'd3;
	localparam logic [2:0] LEN_4 = 3'd4;

	// Kind of work handed to the serializer
	typedef enum logic [1:0] {
		JOB_CHAR   = 2'd0,
		JOB_ESC    = 2'd1,
		JOB_STATUS = 2'd2
	} job_kind_t;

	typedef struct packed {
		job_kind_t   kind;
		logic [6:0]  ch;
		logic [1:0]  st;
		logic [20:0] cp;
	} job_t;

	// Decoder status seen by the top level
	typedef struct packed {
		logic failed;
		logic open_seq;
	} front_stat_t;

	// Serializer status seen by the top level
	typedef struct packed {
		logic busy;
	} back_stat_t;

	// Lowercase hex character of one nibble
	function automatic logic [6:0] hex_char(input logic [3:0] nib);
		logic [6:0] res;
		if (nib < 4'd10) begin
			res = CH_ZERO + {3'b000, nib};
		end else begin
			res = CH_LOW_A + {3'b000, nib} - 7'd10;
		end
		return res;
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/utf8esc_fifo.sv -----
// ----------------------------------------------------------------------------
// utf8esc_fifo
// Short job queue between the decoder and the serializer.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8esc_fifo
	import utf8esc_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  wire  clk,
	input  wire  arst_n,
	input  wire  wr_en,
	input  job_t wr_job,
	input  wire  rd_en,
	output job_t rd_job,
	output logic q_empty,
	output logic q_full
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	job_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign q_empty = (count_q == '0);
	assign q_full  = (count_q == CW'(DEPTH));
	assign rd_job  = mem_q[rd_ptr_q];

	// Store the request at the write pointer
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	// Advance pointers and track fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/utf8esc_front.sv -----
// ----------------------------------------------------------------------------
// utf8esc_front
// UTF-8 decoder: classifies each accepted byte, keeps the partial sequence
// and issues one job per item that produces output.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8esc_front
	import utf8esc_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_ok,
	input  wire         in_op,
	input  wire  [7:0]  in_data,
	output logic        job_valid,
	output job_t        job,
	output front_stat_t stat
);

	logic [1:0]  pending_q, pending_n;
	logic [2:0]  seqlen_q, seqlen_n;
	logic [20:0] accum_q, accum_n;
	logic        failed_q, failed_n;

	logic [20:0] accum_shift;
	logic        printable;
	logic        range_bad;
	logic        emit;

	assign accum_shift = {accum_q[14:0], in_data[5:0]};
	assign printable   = ((in_data >= {1'b0, CH_SPACE}) && (in_data <= {1'b0, CH_TILDE}))
		|| (in_data == {1'b0, CH_TAB}) || (in_data == {1'b0, CH_LF});

	// Check the finished code point against its length
	always_comb begin
		case (seqlen_q)
			LEN_2:   range_bad = (accum_shift < CP_MIN2) || (accum_shift > CP_MAX2);
			LEN_3:   range_bad = (accum_shift < CP_MIN3) || (accum_shift > CP_MAX3);
			default: range_bad = (accum_shift < CP_MIN4) || (accum_shift > CP_MAX4);
		endcase
	end

	// Decode one item
	always_comb begin
		pending_n = pending_q;
		seqlen_n  = seqlen_q;
		accum_n   = accum_q;
		failed_n  = failed_q;
		emit      = 1'b0;
		job       = '{kind: JOB_CHAR, ch: '0, st: ST_OK, cp: '0};
		if (in_op == OP_END) begin
			emit      = 1'b1;
			job.kind  = JOB_STATUS;
			job.st    = (failed_q || (pending_q != 2'd0)) ? ST_BAD : ST_END;
			pending_n = '0;
			seqlen_n  = '0;
			accum_n   = '0;
			failed_n  = 1'b0;
		end else if (failed_q) begin
			emit = 1'b0;
		end else if (pending_q == 2'd0) begin
			if (printable) begin
				emit     = 1'b1;
				job.kind = JOB_CHAR;
				job.ch   = in_data[6:0];
			end else if (in_data == {1'b0, CH_DEL}) begin
				emit     = 1'b1;
				job.kind = JOB_ESC;
				job.cp   = CP_DEL;
			end else if (in_data[7:5] == 3'b110) begin
				seqlen_n  = LEN_2;
				pending_n = 2'd1;
				accum_n   = {16'd0, in_data[4:0]};
			end else if (in_data[7:4] == 4'b1110) begin
				seqlen_n  = LEN_3;
				pending_n = 2'd2;
				accum_n   = {17'd0, in_data[3:0]};
			end else if (in_data[7:3] == 5'b11110) begin
				seqlen_n  = LEN_4;
				pending_n = 2'd3;
				accum_n   = {18'd0, in_data[2:0]};
			end else begin
				emit     = 1'b1;
				job.kind = JOB_STATUS;
				job.st   = ST_BAD;
				failed_n = 1'b1;
			end
		end else if (in_data[7:6] != 2'b10) begin
			emit      = 1'b1;
			job.kind  = JOB_STATUS;
			job.st    = ST_BAD;
			failed_n  = 1'b1;
			pending_n = '0;
			seqlen_n  = '0;
			accum_n   = '0;
		end else begin
			accum_n   = accum_shift;
			pending_n = pending_q - 2'd1;
			if (pending_q == 2'd1) begin
				emit      = 1'b1;
				pending_n = '0;
				seqlen_n  = '0;
				accum_n   = '0;
				if (range_bad) begin
					job.kind = JOB_STATUS;
					job.st   = ST_BAD;
					failed_n = 1'b1;
				end else begin
					job.kind = JOB_ESC;
					job.cp   = accum_shift;
				end
			end
		end
	end

	assign job_valid     = in_ok && emit;
	assign stat.failed   = failed_q;
	assign stat.open_seq = (pending_q != 2'd0);

	// Hold decoder state between bytes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
			seqlen_q  <= '0;
			accum_q   <= '0;
			failed_q  <= 1'b0;
		end else if (in_ok) begin
			pending_q <= pending_n;
			seqlen_q  <= seqlen_n;
			accum_q   <= accum_n;
			failed_q  <= failed_n;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/utf8esc_back.sv -----
// ----------------------------------------------------------------------------
// utf8esc_back
// Serializer: expands the job at the queue head into character or status
// results in a registered output stage, one per cycle unless the stage is held.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8esc_back
	import utf8esc_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	input  job_t        head,
	input  wire         head_empty,
	output logic        head_pop,
	input  wire         pop,
	output logic        empty,
	output logic [6:0]  out_char,
	output logic        char_valid,
	output logic [1:0]  status,
	output logic        last,
	output back_stat_t  stat
);

	logic [2:0] pos_q;
	logic       valid_q;
	logic [6:0] char_q;
	logic       cvalid_q;
	logic [1:0] status_q;
	logic       last_q;

	logic [2:0] ndig;
	logic [2:0] last_pos;
	logic [2:0] dig_idx;
	logic [3:0] nib;
	logic       load;
	logic       is_last;
	logic [6:0] r_char;
	logic       r_cvalid;
	logic [1:0] r_status;

	// Size the escape from the code point
	always_comb begin
		if (head.cp >= CP_SIX_DIG) begin
			ndig = 3'd6;
		end else if (head.cp >= CP_MIN4) begin
			ndig = 3'd5;
		end else begin
			ndig = 3'd4;
		end
	end

	assign last_pos = (head.kind == JOB_ESC) ? ndig + 3'd1 : 3'd0;
	assign is_last  = (pos_q == last_pos);
	assign dig_idx  = ndig + 3'd1 - pos_q;

	// Select the nibble for the current digit
	always_comb begin
		case (dig_idx)
			3'd0:    nib = head.cp[3:0];
			3'd1:    nib = head.cp[7:4];
			3'd2:    nib = head.cp[11:8];
			3'd3:    nib = head.cp[15:12];
			3'd4:    nib = head.cp[19:16];
			3'd5:    nib = {3'b000, head.cp[20]};
			default: nib = 4'd0;
		endcase
	end

	// Build the result for the current position
	always_comb begin
		r_char   = '0;
		r_cvalid = 1'b0;
		r_status = ST_OK;
		case (head.kind)
			JOB_CHAR: begin
				r_char   = head.ch;
				r_cvalid = 1'b1;
			end
			JOB_ESC: begin
				r_cvalid = 1'b1;
				if (pos_q == 3'd0) begin
					r_char = CH_BSLASH;
				end else if (pos_q == 3'd1) begin
					r_char = CH_U;
				end else begin
					r_char = hex_char(nib);
				end
			end
			JOB_STATUS: begin
				r_status = head.st;
			end
			default: begin
				r_status = ST_OK;
			end
		endcase
	end

	assign load      = !head_empty && (!valid_q || pop);
	assign head_pop  = load && is_last;
	assign stat.busy = (pos_q != 3'd0);

	// Advance position within the job
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				pos_q <= is_last ? 3'd0 : pos_q + 3'd1;
			end
			if (load) begin
				valid_q <= 1'b1;
			end else if (pop) begin
				valid_q <= 1'b0;
			end
		end
	end

	// Hold the result until it is taken
	always_ff @(posedge clk) begin
		if (load) begin
			char_q   <= r_char;
			cvalid_q <= r_cvalid;
			status_q <= r_status;
			last_q   <= is_last;
		end
	end

	assign empty      = !valid_q;
	assign out_char   = char_q;
	assign char_valid = cvalid_q;
	assign status     = status_q;
	assign last       = last_q;

endmodule

`default_nettype wire

// ----- hw/rtl/utf8_to_unicode_escape_core.sv -----
// ----------------------------------------------------------------------------
// utf8_to_unicode_escape_core
// UTF-8 byte stream to ASCII with \u escapes: decoder, job queue and
// character serializer.
// ----------------------------------------------------------------------------
//
//  channel  | handshake              | payload
//  ---------+------------------------+--------------------------------------
//  input    | push / full            | opcode, in_byte
//  result   | pop / empty            | out_char, char_valid, status, last
//
//  The decoder takes one request per cycle while the job queue has room.
//  The serializer emits one result per cycle unless held by pop: one for a
//  plain character or status, 6 to 8 for an escape, so escapes set the rate.
//  A completing byte's job enters the queue at the edge that accepts it; the
//  serializer then registers its first result in the output stage.
//  Reset clears decoder state, queue and output stage at once; no sweep.
//  A stalled result side fills the queue (FIFO_DEPTH jobs), then raises full.
//
`default_nettype none

module utf8_to_unicode_escape_core
	import utf8esc_pkg::*;
#(
	parameter int FIFO_DEPTH = 4
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        push,
	output logic       full,
	input  wire        opcode,
	input  wire  [7:0] in_byte,
	output logic       empty,
	input  wire        pop,
	output logic [6:0] out_char,
	output logic       char_valid,
	output logic [1:0] status,
	output logic       last
);

	logic        in_ok;
	logic        job_valid;
	job_t        job;
	job_t        head;
	logic        head_empty;
	logic        head_pop;
	front_stat_t fstat;
	back_stat_t  bstat;

	assign in_ok = push && !full;

	// Decode bytes
	utf8esc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ok     (in_ok),
		.in_op     (opcode),
		.in_data   (in_byte),
		.job_valid (job_valid),
		.job       (job),
		.stat      (fstat)
	);

	// Queue jobs
	utf8esc_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (job_valid),
		.wr_job  (job),
		.rd_en   (head_pop),
		.rd_job  (head),
		.q_empty (head_empty),
		.q_full  (full)
	);

	// Serialize results
	utf8esc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_empty (head_empty),
		.head_pop   (head_pop),
		.pop        (pop),
		.empty      (empty),
		.out_char   (out_char),
		.char_valid (char_valid),
		.status     (status),
		.last       (last),
		.stat       (bstat)
	);

	// An escape in progress keeps its job at the queue head
	a_busy_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		bstat.busy |-> !head_empty)
		else $error("serializer mid-escape with empty queue");

	// An accepted end marker clears the decoder
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ok && (opcode == OP_END)) |=> (!fstat.failed && !fstat.open_seq))
		else $error("decoder state not cleared by end marker");

	// A status result is always the final result of its item
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !char_valid) |-> (last && (status != ST_OK)))
		else $error("status result without last");

	// A character result always carries ok status
	a_char_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && char_valid) |-> (status == ST_OK))
		else $error("character result with non-ok status");

endmodule

`default_nettype wire
